[hdl/fq_alu_pkg.sv]
// ---------------------------------------------------------------------------
// fq_alu_pkg
// Shared types and constants of the Q24.8 fixed-point ALU.
// ---------------------------------------------------------------------------
package fq_alu_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int DIV_STEPS = 8;

  typedef enum logic [4:0] {
    F_ADD        = 5'd0,
    F_SUB        = 5'd1,
    F_MUL        = 5'd2,
    F_DIV        = 5'd3,
    F_GT         = 5'd4,
    F_LT         = 5'd5,
    F_GE         = 5'd6,
    F_LE         = 5'd7,
    F_EQ         = 5'd8,
    F_NE         = 5'd9,
    F_MIN        = 5'd10,
    F_MAX        = 5'd11,
    F_INC        = 5'd12,
    F_DEC        = 5'd13,
    F_FROM_INT   = 5'd14,
    F_TO_INT     = 5'd15,
    F_FROM_FLOAT = 5'd16,
    F_TO_FLOAT   = 5'd17
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_NAN  = 2'd3
  } status_e;

  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;

  // sign plus magnitude to a saturated word; returns {status, word}
  function automatic logic [33:0] clamp_mag(input logic neg, input logic [63:0] mag);
    logic [33:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {ST_SAT, W_MIN};
      else r = {ST_OK, 32'(-mag[31:0])};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {ST_SAT, W_MAX};
      else r = {ST_OK, mag[31:0]};
    end
    return r;
  endfunction

endpackage

[hdl/fixed_point_q24_8_alu.sv]
// ---------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Pipelined Q24.8 ALU: arithmetic, compares, conversions, saturating.
// ---------------------------------------------------------------------------
// Input beats carry an opcode in s_axis_tuser and two raw operands in
// s_axis_tdata; each beat gives exactly one output beat with the result and
// compare flag in m_axis_tdata and the status code in m_axis_tuser.
// The pipeline has eight register stages, and one beat per cycle is sustained
// for every opcode mix while m_axis is not stalled. The divider is unrolled
// over five stages of eight quotient bits each, which sets the depth; the
// multiplier takes one stage.
// A stall on m_axis freezes the whole pipeline and drops s_axis_tready only
// while the output register holds a beat not yet taken; nothing is lost or
// repeated. Reset empties the pipeline; payload registers are not reset.
// ---------------------------------------------------------------------------
module fixed_point_q24_8_alu
  import fq_alu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [4:0]  s_axis_tuser,   // func[4:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result[31:0], flag[32], zero[39:33]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic [8:1] vld_q;
  logic       en;

  assign en            = !vld_q[8] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:1], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: input register
  func_e              func_q [1:7];
  logic signed [31:0] a1_q, b1_q;

  // ---------------- stage 2
  logic signed [32:0] sum2, dif2;
  logic               lt2, eq2;
  logic [31:0]        sres2;
  logic               sflag2;
  status_e            sst2;
  logic [7:0]         fe2;
  logic [23:0]        fman2;
  logic signed [9:0]  fs2;
  logic [31:0]        amag2, bmag2;

  logic [31:0]        res_q  [2:7];
  logic               flag_q [2:7];
  status_e            st_q   [2:7];
  logic signed [63:0] prod2_q;
  logic               ffnan2_q, ffinf2_q, ffneg2_q;
  logic [23:0]        ffman2_q;
  logic signed [9:0]  ffs2_q;
  logic [31:0]        tmag2_q;
  logic               tneg2_q;

  // divider lanes
  logic [31:0] dv_rem_q [2:7];
  logic [39:0] dv_nq_q  [2:7];
  logic [31:0] dv_d_q   [2:7];
  logic        dv_neg_q [2:7];
  logic        dv_dz_q  [2:7];
  logic [31:0] dv_rem_d [3:7];
  logic [39:0] dv_nq_d  [3:7];

  always_comb begin
    sum2   = {a1_q[31], a1_q} + {b1_q[31], b1_q};
    dif2   = {a1_q[31], a1_q} - {b1_q[31], b1_q};
    lt2    = a1_q < b1_q;
    eq2    = a1_q == b1_q;
    sres2  = '0;
    sflag2 = 1'b0;
    sst2   = ST_OK;
    case (func_q[1])
      F_ADD: begin
        if (sum2[32] != sum2[31]) begin
          sres2 = sum2[32] ? W_MIN : W_MAX;
          sst2  = ST_SAT;
        end else sres2 = sum2[31:0];
      end
      F_SUB: begin
        if (dif2[32] != dif2[31]) begin
          sres2 = dif2[32] ? W_MIN : W_MAX;
          sst2  = ST_SAT;
        end else sres2 = dif2[31:0];
      end
      F_GT:  sflag2 = !lt2 && !eq2;
      F_LT:  sflag2 = lt2;
      F_GE:  sflag2 = !lt2;
      F_LE:  sflag2 = lt2 || eq2;
      F_EQ:  sflag2 = eq2;
      F_NE:  sflag2 = !eq2;
      F_MIN: sres2  = lt2 ? a1_q : b1_q;
      F_MAX: sres2  = (!lt2 && !eq2) ? a1_q : b1_q;
      F_INC: begin
        if (a1_q == W_MAX) sst2 = ST_SAT;
        sres2 = (a1_q == W_MAX) ? W_MAX : 32'(a1_q + 32'sd1);
      end
      F_DEC: begin
        if (a1_q == W_MIN) sst2 = ST_SAT;
        sres2 = (a1_q == W_MIN) ? W_MIN : 32'(a1_q - 32'sd1);
      end
      F_FROM_INT: begin
        if (a1_q[31:23] == {9{a1_q[31]}}) sres2 = {a1_q[23:0], 8'h00};
        else begin
          sres2 = a1_q[31] ? W_MIN : W_MAX;
          sst2  = ST_SAT;
        end
      end
      F_TO_INT: sres2 = 32'(a1_q >>> FRAC_BITS);
      default: ;
    endcase

    fe2   = (a1_q[30:23] == 8'd0) ? 8'd1 : a1_q[30:23];
    fman2 = {(a1_q[30:23] != 8'd0), a1_q[22:0]};
    fs2   = signed'({2'b00, fe2}) - 10'sd142;
    amag2 = a1_q[31] ? 32'(-a1_q) : a1_q;
    bmag2 = b1_q[31] ? 32'(-b1_q) : b1_q;
  end

  // ---------------- divider: eight restoring steps per stage
  always_comb begin
    logic [32:0] rt;
    logic [31:0] rem;
    logic [39:0] nq;
    for (int k = 3; k <= 7; k++) begin
      rem = dv_rem_q[k-1];
      nq  = dv_nq_q[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        rt = {rem, nq[39]};
        nq = {nq[38:0], 1'b0};
        if (rt >= {1'b0, dv_d_q[k-1]}) begin
          rt    = rt - {1'b0, dv_d_q[k-1]};
          nq[0] = 1'b1;
        end
        rem = rt[31:0];
      end
      dv_rem_d[k] = rem;
      dv_nq_d[k]  = nq;
    end
  end

  // ---------------- stage 3
  logic [63:0]  pm3, pr3;
  logic [62:0]  fq3;
  logic         fsat3;
  logic [9:0]   sh3;
  logic [24:0]  half3;
  logic [4:0]   p3;

  logic [55:0]  mmag3_q;
  logic         mneg3_q;
  logic [62:0]  fq3_q;
  logic         fsat3_q, fnan3_q, fneg3_q;
  logic [4:0]   p3_q;
  logic [31:0]  tmag3_q;
  logic         tneg3_q;

  always_comb begin
    pm3   = prod2_q[63] ? 64'(-prod2_q) : 64'(prod2_q);
    pr3   = pm3 + 64'd128;
    fq3   = '0;
    fsat3 = ffinf2_q;
    sh3   = 10'(-ffs2_q);
    half3 = '0;
    if (!ffs2_q[9]) begin
      if (ffs2_q > 10'sd38) fsat3 = 1'b1;
      else fq3 = {39'd0, ffman2_q} << ffs2_q[5:0];
    end else if (sh3 <= 10'd25) begin
      half3 = 25'd1 << (sh3[4:0] - 5'd1);
      fq3   = 63'(({1'b0, ffman2_q} + half3) >> sh3[4:0]);
    end
    p3 = '0;
    for (int i = 0; i < 32; i++) begin
      if (tmag2_q[i]) p3 = 5'(i);
    end
  end

  // ---------------- stage 4
  logic [33:0]  mcl4, fcl4;
  logic [31:0]  nm4_d;
  logic [31:0]  nm4_q;
  logic [4:0]   p4_q;
  logic         tneg4_q, tzero4_q;
  logic [31:0]  res4;
  status_e      st4;

  always_comb begin
    mcl4  = clamp_mag(mneg3_q, {8'd0, mmag3_q});
    fcl4  = clamp_mag(fneg3_q, {1'b0, fq3_q});
    nm4_d = tmag3_q << (5'd31 - p3_q);
    res4  = res_q[3];
    st4   = st_q[3];
    case (func_q[3])
      F_MUL: begin
        res4 = mcl4[31:0];
        st4  = status_e'(mcl4[33:32]);
      end
      F_FROM_FLOAT: begin
        if (fnan3_q) begin
          res4 = '0;
          st4  = ST_NAN;
        end else if (fsat3_q) begin
          res4 = fneg3_q ? W_MIN : W_MAX;
          st4  = ST_SAT;
        end else begin
          res4 = fcl4[31:0];
          st4  = status_e'(fcl4[33:32]);
        end
      end
      default: ;
    endcase
  end

  // ---------------- stage 5: float rounding, nearest even
  logic        up5;
  logic [24:0] man5;
  logic [23:0] mf5;
  logic [5:0]  pf5;
  logic [7:0]  ex5;
  logic [31:0] res5;

  always_comb begin
    up5  = nm4_q[7] && ((|nm4_q[6:0]) || nm4_q[8]);
    man5 = {1'b0, nm4_q[31:8]} + 25'(up5);
    if (man5[24]) begin
      mf5 = man5[24:1];
      pf5 = {1'b0, p4_q} + 6'd1;
    end else begin
      mf5 = man5[23:0];
      pf5 = {1'b0, p4_q};
    end
    ex5  = 8'({2'b00, pf5} + 8'd119);
    res5 = res_q[4];
    if (func_q[4] == F_TO_FLOAT) begin
      res5 = tzero4_q ? 32'd0 : {tneg4_q, ex5, mf5[22:0]};
    end
  end

  // ---------------- stage 8: divider rounding and output
  logic        up8;
  logic [40:0] qr8;
  logic [33:0] dcl8;
  logic [31:0] res8_q;
  logic        flag8_q;
  status_e     st8_q;

  always_comb begin
    up8  = {dv_rem_q[7], 1'b0} >= {1'b0, dv_d_q[7]};
    qr8  = {1'b0, dv_nq_q[7]} + 41'(up8);
    dcl8 = clamp_mag(dv_neg_q[7], {23'd0, qr8});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func_q[1] <= func_e'(s_axis_tuser);
      a1_q      <= s_axis_tdata[31:0];
      b1_q      <= s_axis_tdata[63:32];
      for (int k = 2; k <= 7; k++) func_q[k] <= func_q[k-1];

      res_q[2]  <= sres2;
      flag_q[2] <= sflag2;
      st_q[2]   <= sst2;
      prod2_q   <= a1_q * b1_q;
      ffnan2_q  <= (a1_q[30:23] == 8'hFF) && (a1_q[22:0] != 23'd0);
      ffinf2_q  <= (a1_q[30:23] == 8'hFF) && (a1_q[22:0] == 23'd0);
      ffneg2_q  <= a1_q[31];
      ffman2_q  <= fman2;
      ffs2_q    <= fs2;
      tmag2_q   <= amag2;
      tneg2_q   <= a1_q[31];
      dv_rem_q[2] <= '0;
      dv_nq_q[2]  <= {amag2, 8'h00};
      dv_d_q[2]   <= bmag2;
      dv_neg_q[2] <= a1_q[31] ^ b1_q[31];
      dv_dz_q[2]  <= (b1_q == 32'sd0);

      for (int k = 3; k <= 7; k++) begin
        dv_rem_q[k] <= dv_rem_d[k];
        dv_nq_q[k]  <= dv_nq_d[k];
        dv_d_q[k]   <= dv_d_q[k-1];
        dv_neg_q[k] <= dv_neg_q[k-1];
        dv_dz_q[k]  <= dv_dz_q[k-1];
        flag_q[k]   <= flag_q[k-1];
      end

      mmag3_q  <= pr3[63:8];
      mneg3_q  <= prod2_q[63];
      fq3_q    <= fq3;
      fsat3_q  <= fsat3;
      fnan3_q  <= ffnan2_q;
      fneg3_q  <= ffneg2_q;
      p3_q     <= p3;
      tmag3_q  <= tmag2_q;
      tneg3_q  <= tneg2_q;
      res_q[3] <= res_q[2];
      st_q[3]  <= st_q[2];

      nm4_q    <= nm4_d;
      p4_q     <= p3_q;
      tneg4_q  <= tneg3_q;
      tzero4_q <= (tmag3_q == 32'd0);
      res_q[4] <= res4;
      st_q[4]  <= st4;

      res_q[5] <= res5;
      st_q[5]  <= st_q[4];
      res_q[6] <= res_q[5];
      st_q[6]  <= st_q[5];
      res_q[7] <= res_q[6];
      st_q[7]  <= st_q[6];

      flag8_q <= flag_q[7];
      if (func_q[7] == F_DIV) begin
        if (dv_dz_q[7]) begin
          res8_q <= '0;
          st8_q  <= ST_DIVZ;
        end else begin
          res8_q <= dcl8[31:0];
          st8_q  <= status_e'(dcl8[33:32]);
        end
      end else begin
        res8_q <= res_q[7];
        st8_q  <= st_q[7];
      end
    end
  end

  assign m_axis_tvalid = vld_q[8];
  assign m_axis_tdata  = {7'd0, flag8_q, res8_q};
  assign m_axis_tuser  = st8_q;

  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_DIVZ) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("divide by zero with nonzero result");

  a_nan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NAN) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("NaN status with nonzero result");

  a_flag_only_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |->
      (m_axis_tuser == ST_OK) && (m_axis_tdata[31:0] == 32'd0))
    else $error("compare flag with result or status");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

[test/tb_fixed_point_q24_8_alu.sv]
// ---------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu
// Self-checking bench for the Q24.8 ALU: every opcode, operand extremes,
// conversion corner cases and random traffic with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fixed_point_q24_8_alu;
  import fq_alu_pkg::*;

  typedef struct packed {
    logic [31:0] result;
    logic        flag;
    logic [1:0]  status;
  } alu_out_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  alu_out_t expected_q[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       src_idle_en = 1'b1;
  bit       sink_idle_en = 1'b1;

  fixed_point_q24_8_alu u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] sat_word(input logic signed [63:0] v, inout logic [1:0] st);
    if (v > 64'sh7FFF_FFFF) begin
      st = ST_SAT;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      st = ST_SAT;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic logic [31:0] q_to_single(input logic signed [63:0] a);
    logic [63:0] m;
    logic [63:0] man, rem, half;
    int p, sh;
    m = a < 0 ? -a : a;
    if (m == 0) return 32'h0;
    p = 0;
    while (p < 63 && (m >> (p + 1)) != 0) p++;
    if (p <= 23) begin
      man = m << (23 - p);
    end else begin
      sh = p - 23;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      man = m >> sh;
      if (rem > half || (rem == half && man[0])) man++;
      if (man == (64'd1 << 24)) begin
        man >>= 1;
        p++;
      end
    end
    return {a < 0, 8'(p - FRAC_BITS + 127), man[22:0]};
  endfunction

  function automatic logic signed [63:0] single_to_q(input logic [31:0] bits,
                                                    inout logic [1:0] st);
    logic [63:0] man, q;
    int e, s;
    logic neg;
    neg = bits[31];
    e = bits[30:23];
    man = {41'd0, bits[22:0]};
    if (e == 255) begin
      if (man != 0) begin
        st = ST_NAN;
        return 0;
      end
      st = ST_SAT;
      return neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
    end
    if (e == 0) e = 1;
    else man[23] = 1'b1;
    if (man == 0) return 0;
    s = e - 150 + FRAC_BITS;
    if (s >= 0) begin
      if (s > 38) begin
        st = ST_SAT;
        return neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
      end
      q = man << s;
    end else if (-s > 25) begin
      q = 0;
    end else begin
      q = (man + (64'd1 << (-s - 1))) >> -s;
    end
    return sat_word(neg ? -$signed(q) : $signed(q), st);
  endfunction

  function automatic alu_out_t alu_predict(input logic [4:0] fn, input logic [31:0] ra,
                                           input logic [31:0] rb);
    alu_out_t o;
    logic signed [63:0] a, b, r;
    logic [63:0] ma, mb, mag;
    logic neg;
    a = $signed(ra);
    b = $signed(rb);
    r = 0;
    o = '0;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    case (fn)
      F_ADD: r = sat_word(a + b, o.status);
      F_SUB: r = sat_word(a - b, o.status);
      F_MUL: begin
        neg = (a < 0) != (b < 0) && a != 0 && b != 0;
        mag = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r = sat_word(neg ? -$signed(mag) : $signed(mag), o.status);
      end
      F_DIV: begin
        if (b == 0) begin
          o.status = ST_DIVZ;
        end else begin
          neg = (a < 0) != (b < 0);
          mag = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
          r = sat_word(neg ? -$signed(mag) : $signed(mag), o.status);
        end
      end
      F_GT: o.flag = a > b;
      F_LT: o.flag = a < b;
      F_GE: o.flag = a >= b;
      F_LE: o.flag = a <= b;
      F_EQ: o.flag = a == b;
      F_NE: o.flag = a != b;
      F_MIN: r = a < b ? a : b;
      F_MAX: r = a > b ? a : b;
      F_INC: r = sat_word(a + 1, o.status);
      F_DEC: r = sat_word(a - 1, o.status);
      F_FROM_INT: r = sat_word(a * 256, o.status);
      F_TO_INT: r = a >>> FRAC_BITS;
      F_FROM_FLOAT: r = single_to_q(ra, o.status);
      F_TO_FLOAT: r = {32'd0, q_to_single(a)};
      default: r = 0;
    endcase
    o.result = r[31:0];
    return o;
  endfunction

  task automatic send_beat(input logic [4:0] fn, input logic [31:0] a, input logic [31:0] b);
    while (src_idle_en && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(alu_predict(fn, a, b));
    @(negedge clk_i);
  endtask

  // sink side
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 28);
  end

  always @(posedge clk_i) begin
    alu_out_t got, exp_o;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_fixed_point_q24_8_alu: FAIL");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tuser};
        if (expected_q.size() == 0) begin
          $error("unexpected result beat %h", m_axis_tdata);
          errors++;
        end else begin
          exp_o = expected_q.pop_front();
          if (got.result !== exp_o.result) begin
            $error("result: expected %h actual %h", exp_o.result, got.result);
            errors++;
          end
          if (m_axis_tdata[32] !== exp_o.flag) begin
            $error("flag: expected %b actual %b", exp_o.flag, m_axis_tdata[32]);
            errors++;
          end
          if (m_axis_tdata[39:33] !== 7'd0) begin
            $error("pad: expected 0 actual %h", m_axis_tdata[39:33]);
            errors++;
          end
          if (got.status !== exp_o.status) begin
            $error("status: expected %0d actual %0d", exp_o.status, got.status);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(600) - 300;
      1: return $signed($urandom_range(65535)) - 32768;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_beat(F_ADD, 32'h7FFF_FFFF, 32'd1);
    send_beat(F_SUB, 32'h8000_0000, 32'd1);
    send_beat(F_MUL, 32'h0000_0180, 32'hFFFF_FF80);
    send_beat(F_MUL, 32'h8000_0000, 32'h8000_0000);
    send_beat(F_MUL, 32'd1, 32'd128);
    send_beat(F_DIV, 32'd256, 32'd0);
    send_beat(F_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    send_beat(F_DIV, 32'd1, 32'd3);
    send_beat(F_GT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(F_LT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(F_GE, 32'd5, 32'd5);
    send_beat(F_LE, 32'd6, 32'd5);
    send_beat(F_EQ, 32'd5, 32'd5);
    send_beat(F_NE, 32'd5, 32'd5);
    send_beat(F_MIN, 32'hFFFF_FFFF, 32'd1);
    send_beat(F_MAX, 32'hFFFF_FFFF, 32'd1);
    send_beat(F_INC, 32'h7FFF_FFFF, 32'd0);
    send_beat(F_DEC, 32'h8000_0000, 32'd0);
    send_beat(F_FROM_INT, 32'h0080_0000, 32'd0);
    send_beat(F_TO_INT, 32'hFFFF_FF01, 32'd0);
    send_beat(F_FROM_FLOAT, 32'h7FC0_0000, 32'd0);
    send_beat(F_FROM_FLOAT, 32'hFF80_0000, 32'd0);
    send_beat(F_FROM_FLOAT, 32'h8000_0000, 32'd0);
    send_beat(F_FROM_FLOAT, 32'h3B00_0000, 32'd0);
    send_beat(F_TO_FLOAT, 32'h7FFF_FFFF, 32'd0);
    send_beat(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(input int n);
    logic [4:0] fn;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      sink_idle_en = !(i >= n / 2 && i < n / 2 + 150);
      src_idle_en = sink_idle_en;
      fn = $urandom_range(99) < 3 ? 5'($urandom_range(31, 18)) : 5'($urandom_range(17));
      a = rand_operand();
      if (fn == F_FROM_FLOAT && $urandom_range(1))
        a = {1'($urandom()), 8'($urandom_range(100, 160)), 23'($urandom())};
      send_beat(fn, a, $urandom_range(9) == 0 ? 32'd0 : rand_operand());
    end
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(1200);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("tb_fixed_point_q24_8_alu: PASS");
    else $display("tb_fixed_point_q24_8_alu: FAIL");
    $finish;
  end

endmodule
